// ===== rtl/hps_pkg.sv =====
package hps_pkg;

  // timer width of the off-target counter
  localparam int TIMER_BITS = 21;

  // field widths
  localparam int TEMP_W     = 12;
  localparam int MARGIN_W   = 11;
  localparam int TIMEOUT_W  = 20;
  localparam int WINDOW_W   = 16;
  localparam int DELAY_W    = 10;
  localparam int LEVEL_W    = 8;
  localparam int PID_W      = 16;
  localparam int READ_W     = 11;
  localparam int WIN_W      = 17;

  // stream and configuration port widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // result beat layout
  localparam int OUT_HEATER_BIT = 0;
  localparam int OUT_PUMP_LSB   = 1;
  localparam int OUT_MODE_LSB   = 9;
  localparam int OUT_FAULT_LSB  = 11;
  localparam int OUT_TAKEN_BIT  = 13;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_TUNE = 2'd2,
    MODE_ERR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_READ    = 2'd1,
    FAULT_HOT     = 2'd2,
    FAULT_TIMEOUT = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_IDLE = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_TUNE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_TEMP = 3'd0,
    CFG_TEMP_MARGIN = 3'd1,
    CFG_MAX_TEMP    = 3'd2,
    CFG_TIMEOUT     = 3'd3,
    CFG_WINDOW      = 3'd4,
    CFG_READ_DELAY  = 3'd5,
    CFG_PUMP_LEVEL  = 3'd6
  } cfg_idx_e;

  // register reset values
  localparam logic [TEMP_W-1:0]    RST_TARGET_TEMP = 12'd800;
  localparam logic [MARGIN_W-1:0]  RST_TEMP_MARGIN = 11'd80;
  localparam logic [TEMP_W-1:0]    RST_MAX_TEMP    = 12'd1600;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT     = 20'd300000;
  localparam logic [WINDOW_W-1:0]  RST_WINDOW      = 16'd1000;
  localparam logic [DELAY_W-1:0]   RST_READ_DELAY  = 10'd750;
  localparam logic [LEVEL_W-1:0]   RST_PUMP_LEVEL  = 8'd255;

  typedef struct packed {
    logic [TEMP_W-1:0]    target_temp;
    logic [MARGIN_W-1:0]  temp_margin;
    logic [TEMP_W-1:0]    max_temp;
    logic [TIMEOUT_W-1:0] heat_timeout_ms;
    logic [WINDOW_W-1:0]  window_ms;
    logic [DELAY_W-1:0]   read_delay_ms;
    logic [LEVEL_W-1:0]   pump_level;
  } cfg_t;

  typedef struct packed {
    cmd_e              command;
    logic [TEMP_W-1:0] temperature;
    logic              sensor_fault;
    logic [PID_W-1:0]  pid_output;
    logic              autotune_done;
  } item_t;

  typedef struct packed {
    logic               heater_on;
    logic [LEVEL_W-1:0] pump_out;
    mode_e              mode;
    fault_e             fault_code;
    logic               read_taken;
  } result_t;

endpackage

// ===== rtl/hps_cfg_regs.sv =====
module hps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [hps_pkg::CFG_IDX_W-1:0]    wr_index_i,
  input  logic [hps_pkg::CFG_DATA_W-1:0]   wr_data_i,
  output hps_pkg::cfg_t                    cfg_o
);

  hps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp     <= hps_pkg::RST_TARGET_TEMP;
      cfg_q.temp_margin     <= hps_pkg::RST_TEMP_MARGIN;
      cfg_q.max_temp        <= hps_pkg::RST_MAX_TEMP;
      cfg_q.heat_timeout_ms <= hps_pkg::RST_TIMEOUT;
      cfg_q.window_ms       <= hps_pkg::RST_WINDOW;
      cfg_q.read_delay_ms   <= hps_pkg::RST_READ_DELAY;
      cfg_q.pump_level      <= hps_pkg::RST_PUMP_LEVEL;
    end else if (wr_en_i) begin
      unique case (hps_pkg::cfg_idx_e'(wr_index_i))
        hps_pkg::CFG_TARGET_TEMP: cfg_q.target_temp <= wr_data_i[hps_pkg::TEMP_W-1:0];
        hps_pkg::CFG_TEMP_MARGIN: cfg_q.temp_margin <= wr_data_i[hps_pkg::MARGIN_W-1:0];
        hps_pkg::CFG_MAX_TEMP:    cfg_q.max_temp    <= wr_data_i[hps_pkg::TEMP_W-1:0];
        hps_pkg::CFG_TIMEOUT:     cfg_q.heat_timeout_ms <= wr_data_i[hps_pkg::TIMEOUT_W-1:0];
        hps_pkg::CFG_WINDOW:      cfg_q.window_ms   <= wr_data_i[hps_pkg::WINDOW_W-1:0];
        hps_pkg::CFG_READ_DELAY:  cfg_q.read_delay_ms <= wr_data_i[hps_pkg::DELAY_W-1:0];
        hps_pkg::CFG_PUMP_LEVEL:  cfg_q.pump_level  <= wr_data_i[hps_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hps_core.sv =====
module hps_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  hps_pkg::item_t    item_i,
  input  hps_pkg::cfg_t     cfg_i,
  output hps_pkg::result_t  result_o
);

  localparam int CMP_W = (hps_pkg::TIMER_BITS > hps_pkg::TIMEOUT_W) ?
                         hps_pkg::TIMER_BITS : hps_pkg::TIMEOUT_W;
  localparam logic [hps_pkg::READ_W-1:0]     READ_MAX  = '1;
  localparam logic [hps_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [hps_pkg::WIN_W-1:0]      WIN_MAX   = '1;

  hps_pkg::mode_e                mode_q, mode_d;
  hps_pkg::fault_e               fault_q, fault_d;
  logic [hps_pkg::READ_W-1:0]    read_wait_q, read_wait_d;
  logic [hps_pkg::TIMER_BITS-1:0] off_time_q, off_time_d;
  logic [hps_pkg::WIN_W-1:0]     win_q, win_d;
  logic                          pump_q, pump_d;

  logic                          read_due;
  logic                          read_ok;
  logic signed [hps_pkg::TEMP_W:0] diff;
  logic [hps_pkg::TEMP_W:0]      abs_diff;
  logic                          too_hot;
  logic                          in_band;
  logic                          timed_out;
  logic                          heater;

  // temperature checks, all on the sample of this tick
  always_comb begin
    diff     = $signed({item_i.temperature[hps_pkg::TEMP_W-1], item_i.temperature})
             - $signed({cfg_i.target_temp[hps_pkg::TEMP_W-1], cfg_i.target_temp});
    abs_diff = diff[hps_pkg::TEMP_W] ? (hps_pkg::TEMP_W + 1)'(0) - diff : diff;
    too_hot  = $signed(item_i.temperature) > $signed(cfg_i.max_temp);
    in_band  = abs_diff < (hps_pkg::TEMP_W + 1)'(cfg_i.temp_margin);
  end

  always_comb begin
    mode_d      = mode_q;
    fault_d     = fault_q;
    pump_d      = pump_q;
    read_ok     = 1'b0;
    heater      = 1'b0;
    timed_out   = 1'b0;

    // saturating timers
    read_wait_d = (read_wait_q == READ_MAX) ? read_wait_q : read_wait_q + 1'b1;
    off_time_d  = (off_time_q == TIMER_MAX) ? off_time_q : off_time_q + 1'b1;
    win_d       = (win_q == WIN_MAX) ? win_q : win_q + 1'b1;

    // mode command
    if (mode_q != hps_pkg::MODE_ERR) begin
      unique case (item_i.command)
        hps_pkg::CMD_NONE: ;
        hps_pkg::CMD_IDLE: begin
          pump_d = 1'b0;
          mode_d = hps_pkg::MODE_IDLE;
        end
        hps_pkg::CMD_RUN: begin
          pump_d     = 1'b1;
          win_d      = '0;
          off_time_d = '0;
          mode_d     = hps_pkg::MODE_RUN;
        end
        hps_pkg::CMD_TUNE: begin
          pump_d = 1'b1;
          mode_d = hps_pkg::MODE_TUNE;
        end
        default: ;
      endcase
    end

    // reading
    timed_out = CMP_W'(off_time_d) > CMP_W'(cfg_i.heat_timeout_ms);
    read_due  = (mode_d != hps_pkg::MODE_ERR) &&
                (read_wait_d >= hps_pkg::READ_W'(cfg_i.read_delay_ms));
    if (read_due) begin
      read_ok = 1'b1;
      if (item_i.sensor_fault) begin
        mode_d  = hps_pkg::MODE_ERR;
        fault_d = hps_pkg::FAULT_READ;
        read_ok = 1'b0;
      end else if (mode_d != hps_pkg::MODE_IDLE) begin
        if (too_hot) begin
          mode_d  = hps_pkg::MODE_ERR;
          fault_d = hps_pkg::FAULT_HOT;
          read_ok = 1'b0;
        end else if (in_band) begin
          off_time_d = '0;
        end else if (timed_out) begin
          mode_d  = hps_pkg::MODE_ERR;
          fault_d = hps_pkg::FAULT_TIMEOUT;
          read_ok = 1'b0;
        end
      end
      if (read_ok) begin
        read_wait_d = '0;
      end
    end

    // autotune finished
    if (mode_d == hps_pkg::MODE_TUNE && item_i.autotune_done) begin
      pump_d = 1'b0;
      mode_d = hps_pkg::MODE_IDLE;
    end

    // heater window
    if (mode_d == hps_pkg::MODE_RUN || mode_d == hps_pkg::MODE_TUNE) begin
      if (win_d > hps_pkg::WIN_W'(cfg_i.window_ms)) begin
        win_d = win_d - hps_pkg::WIN_W'(cfg_i.window_ms);
      end
      heater = hps_pkg::WIN_W'(item_i.pid_output) >= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hps_pkg::MODE_IDLE;
      fault_q     <= hps_pkg::FAULT_NONE;
      read_wait_q <= '0;
      off_time_q  <= '0;
      win_q       <= '0;
      pump_q      <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      fault_q     <= fault_d;
      read_wait_q <= read_wait_d;
      off_time_q  <= off_time_d;
      win_q       <= win_d;
      pump_q      <= pump_d;
    end
  end

  always_comb begin
    result_o.heater_on  = heater;
    result_o.pump_out   = pump_d ? cfg_i.pump_level : '0;
    result_o.mode       = mode_d;
    result_o.fault_code = fault_d;
    result_o.read_taken = read_ok;
  end

endmodule

// ===== rtl/heater_process_supervisor.sv =====
// heater process supervisor, one input beat per millisecond tick
// an accepted input beat is held in in_q, and its result beat is registered in out_q on its step
// throughput: one beat per cycle while results drain, set by the single register-to-register step
// of the tick logic; while a result waits one more input beat is held
// reset (rst_ni low, asynchronous): configuration back to defaults, mode idle,
// no fault, pump off, all timers zero, both stream stages empty
module heater_process_supervisor (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // tick beats
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [1:0] command, [13:2] temperature, [14] sensor_fault,
  // [30:15] pid_output, [31] autotune_done
  input  logic [hps_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,

  // result beats
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] heater_on, [8:1] pump_out, [10:9] mode, [12:11] fault_code,
  // [13] read_taken, [15:14] zero
  output logic [hps_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,

  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hps_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  hps_pkg::cfg_t    cfg;
  hps_pkg::item_t   in_q;
  logic             in_valid_q;
  hps_pkg::result_t res;
  hps_pkg::result_t out_q;
  logic             out_valid_q;
  logic             step;
  logic             in_beat;

  // writes are always taken; the user must make them only while the block is idle, which it does not enforce
  assign cfg_ready_o = 1'b1;

  hps_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the held tick advances when the result register is free or draining
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_beat) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload, unpacked from the beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_q.command       <= hps_pkg::cmd_e'(s_axis_tdata_i[1:0]);
      in_q.temperature   <= s_axis_tdata_i[13:2];
      in_q.sensor_fault  <= s_axis_tdata_i[14];
      in_q.pid_output    <= s_axis_tdata_i[30:15];
      in_q.autotune_done <= s_axis_tdata_i[31];
    end
  end

  // mode, fault and timer state; one tick per step
  hps_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.read_taken, out_q.fault_code, out_q.mode,
                            out_q.pump_out, out_q.heater_on};

endmodule

// ===== rtl/hps_checker.sv =====
module hps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [hps_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  logic       out_beat;
  logic [1:0] mode;
  logic [1:0] fault;
  logic       heater;
  logic       taken;
  logic [hps_pkg::LEVEL_W-1:0] pump;
  logic       err_seen_q;
  logic [1:0] err_code_q;

  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;
  assign mode     = m_axis_tdata_o[hps_pkg::OUT_MODE_LSB +: 2];
  assign fault    = m_axis_tdata_o[hps_pkg::OUT_FAULT_LSB +: 2];
  assign heater   = m_axis_tdata_o[hps_pkg::OUT_HEATER_BIT];
  assign taken    = m_axis_tdata_o[hps_pkg::OUT_TAKEN_BIT];
  assign pump     = m_axis_tdata_o[hps_pkg::OUT_PUMP_LSB +: hps_pkg::LEVEL_W];

  // remember the first error shown on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
      err_code_q <= hps_pkg::FAULT_NONE;
    end else if (out_beat && !err_seen_q && mode == hps_pkg::MODE_ERR) begin
      err_seen_q <= 1'b1;
      err_code_q <= fault;
    end
  end

  a_fault_iff_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> ((mode == hps_pkg::MODE_ERR) == (fault != hps_pkg::FAULT_NONE)))
    else $error("fault code and error mode disagree");

  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && mode == hps_pkg::MODE_ERR |-> !heater && !taken)
    else $error("heater or read active in error mode");

  a_idle_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && mode == hps_pkg::MODE_IDLE |-> !heater && pump == '0)
    else $error("heater or pump active in idle mode");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && err_seen_q |-> mode == hps_pkg::MODE_ERR && fault == err_code_q)
    else $error("error mode left or fault code changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

endmodule

bind heater_process_supervisor hps_checker u_hps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== sim/heater_process_supervisor_tb.sv =====
module heater_process_supervisor_tb;
  import hps_pkg::*;

  // cycles with no beat on any channel before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // idle time after the last result has drained, to catch stray beats
  localparam int DRAIN_CYCLES = 10;
  localparam int TEMP_LO      = -880;
  localparam int TEMP_HI      = 2000;
  localparam int RANDOM_PHASES = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // [1:0] command, [13:2] temperature, [14] sensor_fault,
  // [30:15] pid_output, [31] autotune_done
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // [0] heater_on, [8:1] pump_out, [10:9] mode, [12:11] fault_code,
  // [13] read_taken, [15:14] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  heater_process_supervisor uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // supervisor state as the block holds it, timers at their own widths
  typedef struct packed {
    mode_e                 mode;
    fault_e                fault;
    logic [READ_W-1:0]     read_wait;
    logic [TIMER_BITS-1:0] off_time;
    logic [WIN_W-1:0]      win_pos;
    logic                  pump_on;
  } heater_state_t;

  cfg_t          regs;      // register contents as the block should hold them
  heater_state_t plant;     // advanced when a tick beat is accepted
  heater_state_t plan;      // advanced when a tick is queued, steers the stimulus
  item_t         tick_q[$];
  result_t       outcome_q[$];
  item_t         on_bus;

  int  queued_cnt = 0;
  int  checked_cnt = 0;
  int  fails = 0;
  int  idle_cycles = 0;
  int  send_hold = 0;
  int  recv_hold = 0;
  bit  send_gaps = 1'b1;
  bit  recv_stalls = 1'b1;
  int  trip_kind = 0;       // fault the closing phase tries to provoke

  // one millisecond tick of the supervisor
  function automatic result_t tick_supervisor(inout heater_state_t st, input item_t it);
    result_t r;
    int      temp;
    int      offset;
    logic    ok;
    r    = '0;
    temp = int'($signed(it.temperature));

    // free-running timers, all saturating
    if (st.read_wait != '1) st.read_wait = st.read_wait + READ_W'(1);
    if (st.off_time != '1) st.off_time = st.off_time + TIMER_BITS'(1);
    if (st.win_pos != '1) st.win_pos = st.win_pos + WIN_W'(1);

    // commands, ignored once the error mode latched
    if (st.mode != MODE_ERR) begin
      case (it.command)
        CMD_IDLE: begin
          st.pump_on = 1'b0;
          st.mode    = MODE_IDLE;
        end
        CMD_RUN: begin
          st.pump_on  = 1'b1;
          st.win_pos  = '0;
          st.off_time = '0;
          st.mode     = MODE_RUN;
        end
        CMD_TUNE: begin
          st.pump_on = 1'b1;
          st.mode    = MODE_TUNE;
        end
        default: ;
      endcase
    end

    // reading due: sensor, over-temperature and off-target checks
    if (st.mode != MODE_ERR && int'(st.read_wait) >= int'(regs.read_delay_ms)) begin
      ok = 1'b1;
      if (it.sensor_fault) begin
        st.mode  = MODE_ERR;
        st.fault = FAULT_READ;
        ok       = 1'b0;
      end else if (st.mode != MODE_IDLE) begin
        offset = temp - int'($signed(regs.target_temp));
        if (offset < 0) offset = -offset;
        if (temp > int'($signed(regs.max_temp))) begin
          st.mode  = MODE_ERR;
          st.fault = FAULT_HOT;
          ok       = 1'b0;
        end else if (offset < int'(regs.temp_margin)) begin
          st.off_time = '0;
        end else if (int'(st.off_time) > int'(regs.heat_timeout_ms)) begin
          st.mode  = MODE_ERR;
          st.fault = FAULT_TIMEOUT;
          ok       = 1'b0;
        end
      end
      // an erring read leaves the read timer running
      if (ok) begin
        st.read_wait = '0;
        r.read_taken = 1'b1;
      end
    end

    if (st.mode == MODE_TUNE && it.autotune_done) begin
      st.pump_on = 1'b0;
      st.mode    = MODE_IDLE;
    end

    // time-proportioned heater, window folded back once per tick
    if (st.mode == MODE_RUN || st.mode == MODE_TUNE) begin
      if (int'(st.win_pos) > int'(regs.window_ms))
        st.win_pos = st.win_pos - WIN_W'(regs.window_ms);
      r.heater_on = int'(it.pid_output) >= int'(st.win_pos);
    end

    r.pump_out   = st.pump_on ? regs.pump_level : '0;
    r.mode       = st.mode;
    r.fault_code = st.fault;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int clip_temp(int t);
    if (t < TEMP_LO) return TEMP_LO;
    if (t > TEMP_HI) return TEMP_HI;
    return t;
  endfunction

  // register value: an extreme now and then, else a working range
  function automatic int pick(int lo, int hi, int wlo, int whi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return lo;
    if (r < 4) return hi;
    return wlo + int'($urandom_range(0, whi - wlo));
  endfunction

  // candidate tick with temperatures clustered where the checks decide
  function automatic item_t draw_tick(bit trip);
    item_t it;
    int    r;
    int    t;
    int    tgt;
    int    mg;
    int    hot;
    tgt = int'($signed(regs.target_temp));
    mg  = int'(regs.temp_margin);
    hot = int'($signed(regs.max_temp));
    if ($urandom_range(0, 99) < 76) it.command = CMD_NONE;
    else it.command = cmd_e'($urandom_range(1, 3));
    r = $urandom_range(0, 9);
    if (r < 5) t = tgt - mg + int'($urandom_range(0, 2 * mg));
    else if (r < 7) t = hot - 2 + int'($urandom_range(0, 4));
    else t = TEMP_LO + int'($urandom_range(0, TEMP_HI - TEMP_LO));
    if (trip && trip_kind == FAULT_HOT) t = hot + 1 + int'($urandom_range(0, 3));
    if (trip && trip_kind == FAULT_TIMEOUT) t = tgt - mg - 1 - int'($urandom_range(0, 50));
    it.temperature = TEMP_W'(clip_temp(t));
    if (trip && trip_kind == FAULT_READ) it.sensor_fault = $urandom_range(0, 1);
    else it.sensor_fault = ($urandom_range(0, 7) == 0);
    r = $urandom_range(0, 99);
    if (r < 40) it.pid_output = PID_W'($urandom_range(0, int'(regs.window_ms) + 2));
    else if (r < 50) it.pid_output = (r < 45) ? '1 : '0;
    else it.pid_output = PID_W'($urandom);
    it.autotune_done = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  task automatic flag(string msg);
    if (fails < 40) $display("mismatch: %s", msg);
    fails++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag($sformatf("beat %0d %s got %0h want %0h", checked_cnt, name, got, want));
  endtask

  task automatic push_tick(cmd_e c, int t, bit f, int p, bit d);
    item_t it;
    it.command       = c;
    it.temperature   = TEMP_W'(t);
    it.sensor_fault  = f;
    it.pid_output    = PID_W'(p);
    it.autotune_done = d;
    void'(tick_supervisor(plan, it));
    tick_q.push_back(it);
    queued_cnt++;
  endtask

  // queue ticks; unless tripping, a tick that would latch an error is
  // redrawn a few times and then replaced by a plain go-idle tick
  task automatic fill_ticks(int count, bit trip);
    item_t         cand;
    heater_state_t trial;
    bit            safe;
    for (int i = 0; i < count; i++) begin
      if (plan.mode == MODE_ERR) begin
        // error latched: anything goes
        cand.command       = cmd_e'($urandom_range(0, 3));
        cand.temperature   = TEMP_W'(TEMP_LO + int'($urandom_range(0, TEMP_HI - TEMP_LO)));
        cand.sensor_fault  = $urandom_range(0, 1);
        cand.pid_output    = PID_W'($urandom);
        cand.autotune_done = $urandom_range(0, 1);
      end else begin
        safe = 1'b0;
        for (int k = 0; k < 6 && !safe; k++) begin
          cand  = draw_tick(trip);
          trial = plan;
          void'(tick_supervisor(trial, cand));
          safe  = trip || trial.mode != MODE_ERR;
        end
        if (!safe) begin
          cand.command      = CMD_IDLE;
          cand.sensor_fault = 1'b0;
        end
      end
      push_tick(cand.command, int'($signed(cand.temperature)), cand.sensor_fault,
                int'(cand.pid_output), cand.autotune_done);
    end
  endtask

  // register write, unused upper data bits left random
  task automatic write_reg(cfg_idx_e idx, int val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    case (idx)
      CFG_TARGET_TEMP: data[TEMP_W-1:0]   = TEMP_W'(val);
      CFG_TEMP_MARGIN: data[MARGIN_W-1:0] = MARGIN_W'(val);
      CFG_MAX_TEMP:    data[TEMP_W-1:0]   = TEMP_W'(val);
      CFG_TIMEOUT:     data               = CFG_DATA_W'(val);
      CFG_WINDOW:      data[WINDOW_W-1:0] = WINDOW_W'(val);
      CFG_READ_DELAY:  data[DELAY_W-1:0]  = DELAY_W'(val);
      default:         data[LEVEL_W-1:0]  = LEVEL_W'(val);
    endcase
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TARGET_TEMP: regs.target_temp     = data[TEMP_W-1:0];
      CFG_TEMP_MARGIN: regs.temp_margin     = data[MARGIN_W-1:0];
      CFG_MAX_TEMP:    regs.max_temp        = data[TEMP_W-1:0];
      CFG_TIMEOUT:     regs.heat_timeout_ms = data[TIMEOUT_W-1:0];
      CFG_WINDOW:      regs.window_ms       = data[WINDOW_W-1:0];
      CFG_READ_DELAY:  regs.read_delay_ms   = data[DELAY_W-1:0];
      default:         regs.pump_level      = data[LEVEL_W-1:0];
    endcase
  endtask

  // sender holds off until every queued tick has come back as a result
  task automatic wait_drained();
    while (checked_cnt != queued_cnt) @(negedge clk_i);
  endtask

  // tick driver: predicts on acceptance, then loads the next beat or a gap
  always @(posedge clk_i) begin : tick_driver
    result_t due;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        due = tick_supervisor(plant, on_bus);
        outcome_q.push_back(due);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_hold > 0) begin
          send_hold--;
          s_axis_tvalid_i <= 1'b0;
        end else if (tick_q.size() > 0) begin
          on_bus = tick_q.pop_front();
          s_axis_tdata_i <= {on_bus.autotune_done, on_bus.pid_output, on_bus.sensor_fault,
                             on_bus.temperature, on_bus.command};
          s_axis_tvalid_i <= 1'b1;
          send_hold = send_gaps ? idle_span() : 0;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: each beat against the oldest outstanding prediction
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (outcome_q.size() == 0) begin
          flag($sformatf("result beat %h with no tick outstanding", m_axis_tdata_o));
        end else begin
          want = outcome_q.pop_front();
          check_field("heater_on", m_axis_tdata_o[OUT_HEATER_BIT], want.heater_on);
          check_field("pump_out", m_axis_tdata_o[OUT_PUMP_LSB +: LEVEL_W], want.pump_out);
          check_field("mode", m_axis_tdata_o[OUT_MODE_LSB +: 2], want.mode);
          check_field("fault_code", m_axis_tdata_o[OUT_FAULT_LSB +: 2], want.fault_code);
          check_field("read_taken", m_axis_tdata_o[OUT_TAKEN_BIT], want.read_taken);
          check_field("pad", m_axis_tdata_o[OUT_DATA_W-1:OUT_TAKEN_BIT+1], '0);
          checked_cnt++;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (recv_stalls && $urandom_range(0, 3) == 0) recv_hold = idle_span();
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int tgt;
    int mx;
    regs = '{target_temp: RST_TARGET_TEMP, temp_margin: RST_TEMP_MARGIN,
             max_temp: RST_MAX_TEMP, heat_timeout_ms: RST_TIMEOUT,
             window_ms: RST_WINDOW, read_delay_ms: RST_READ_DELAY,
             pump_level: RST_PUMP_LEVEL};
    plant = '0;
    plan  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, slow reads and a long window
    fill_ticks(40, 1'b0);
    wait_drained();

    // directed: reads every tick, wide margin, three-tick window
    write_reg(CFG_TARGET_TEMP, 0);
    write_reg(CFG_TEMP_MARGIN, 2047);
    write_reg(CFG_MAX_TEMP, TEMP_HI);
    write_reg(CFG_TIMEOUT, 1);
    write_reg(CFG_WINDOW, 3);
    write_reg(CFG_READ_DELAY, 0);
    write_reg(CFG_PUMP_LEVEL, 'hA5);
    push_tick(CMD_NONE, TEMP_LO, 1'b0, 0, 1'b0);      // idle read at coldest sample
    push_tick(CMD_RUN, TEMP_HI, 1'b0, 0, 1'b0);       // at max is not too hot, heater on at 0
    push_tick(CMD_NONE, 0, 1'b0, 0, 1'b0);
    push_tick(CMD_NONE, 1, 1'b0, 65535, 1'b0);
    push_tick(CMD_NONE, -1, 1'b0, 2, 1'b0);
    push_tick(CMD_NONE, 2, 1'b0, 1, 1'b0);            // window folds back
    push_tick(CMD_RUN, 3, 1'b0, 0, 1'b0);             // repeated run restarts the window
    push_tick(CMD_TUNE, 4, 1'b0, 'hAAAA, 1'b0);
    push_tick(CMD_TUNE, 5, 1'b0, 'h5555, 1'b0);
    push_tick(CMD_NONE, 6, 1'b0, 7, 1'b1);            // autotune finished
    push_tick(CMD_NONE, 7, 1'b0, 0, 1'b1);            // done flag while idle
    push_tick(CMD_RUN, -2, 1'b0, 3, 1'b1);            // done flag while running
    push_tick(CMD_IDLE, 1999, 1'b0, 4, 1'b0);
    push_tick(CMD_TUNE, -879, 1'b0, 65535, 1'b1);     // tune and done in one tick
    push_tick(CMD_IDLE, 0, 1'b0, 0, 1'b0);
    wait_drained();

    // random settings, each phase starting from a drained block
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      tgt = pick(TEMP_LO, TEMP_HI, -300, 1500);
      mx  = clip_temp(pick(TEMP_LO, TEMP_HI, tgt + 50, tgt + 600));
      write_reg(CFG_TARGET_TEMP, tgt);
      write_reg(CFG_TEMP_MARGIN, pick(0, 2047, 1, 300));
      write_reg(CFG_MAX_TEMP, mx);
      write_reg(CFG_TIMEOUT, ($urandom_range(0, 19) == 0) ? 0 : pick(1, 1048575, 5, 400));
      write_reg(CFG_WINDOW, ($urandom_range(0, 19) == 0) ? 0 : pick(1, 65535, 2, 40));
      write_reg(CFG_READ_DELAY, pick(0, 1023, 0, 12));
      write_reg(CFG_PUMP_LEVEL, pick(0, 255, 1, 254));
      fill_ticks(65, 1'b0);
      wait_drained();
    end

    // closing phase: drive into one of the sticky faults, then keep going
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    trip_kind   = $urandom_range(FAULT_READ, FAULT_TIMEOUT);
    write_reg(CFG_TARGET_TEMP, 200);
    write_reg(CFG_TEMP_MARGIN, 20);
    write_reg(CFG_MAX_TEMP, 1000);
    write_reg(CFG_TIMEOUT, $urandom_range(5, 40));
    write_reg(CFG_WINDOW, $urandom_range(1, 20));
    write_reg(CFG_READ_DELAY, $urandom_range(0, 3));
    write_reg(CFG_PUMP_LEVEL, $urandom_range(0, 255));
    fill_ticks(100, 1'b1);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
